// ----- src/mod_prime_pow_inverse_unit_defines.svh -----
// Assertion macros for the modular power / inverse unit.
// Included by every RTL file that carries concurrent assertions; no dependencies.
`ifndef MOD_PRIME_POW_INVERSE_UNIT_DEFINES_SVH
`define MOD_PRIME_POW_INVERSE_UNIT_DEFINES_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define MPPI_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mppi: invariant violated");
// Same-cycle implication.
`define MPPI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mppi: implication violated");
// Next-cycle implication.
`define MPPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mppi: next-cycle implication violated");
`else
`define MPPI_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define MPPI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MPPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/mppi_pkg.sv -----
// Package for the modular power / inverse unit: modulus constants,
// microcode word types and the microcode ROM. No dependencies.
`timescale 1ns / 1ps

package mppi_pkg;

    localparam int unsigned RES_W  = 30;
    localparam int unsigned PROD_W = 2 * RES_W;

    localparam logic [RES_W-1:0] P_MOD      = 30'd1000000007;
    localparam logic [RES_W-1:0] FERMAT_EXP = 30'd1000000005;
    // floor(2^60 / P)
    localparam logic [30:0]      BARRETT_MU = 31'd1152921496;

    typedef logic [3:0] upc_t;

    localparam upc_t UPC_IDLE = 4'd0;
    localparam upc_t UPC_LOOP = 4'd6;
    localparam upc_t UPC_DONE = 4'd12;

    typedef enum logic [2:0] {
        UOP_IDLE,
        UOP_RED,
        UOP_NOP,
        UOP_ISQ,
        UOP_IAM,
        UOP_WSQ,
        UOP_WACC,
        UOP_DONE
    } uop_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_START,
        JC_EXP_ZERO,
        JC_EXP_MORE
    } jcond_t;

    typedef struct packed {
        uop_t   op;
        jcond_t cond;
        upc_t   target;
    } uword_t;

    typedef struct packed {
        logic start;
        logic exp_zero;
        logic exp_more;
    } dp_status_t;

    function automatic uword_t ucode_rom(upc_t pc);
        uword_t w;
        unique case (pc)
            4'd0:    w = '{op: UOP_IDLE, cond: JC_NO_START, target: UPC_IDLE};
            4'd1:    w = '{op: UOP_RED,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd2:    w = '{op: UOP_RED,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd3:    w = '{op: UOP_RED,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd4:    w = '{op: UOP_RED,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd5:    w = '{op: UOP_NOP,  cond: JC_EXP_ZERO, target: UPC_DONE};
            4'd6:    w = '{op: UOP_ISQ,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd7:    w = '{op: UOP_IAM,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd8:    w = '{op: UOP_NOP,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd9:    w = '{op: UOP_NOP,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd10:   w = '{op: UOP_WSQ,  cond: JC_NEVER,    target: UPC_IDLE};
            4'd11:   w = '{op: UOP_WACC, cond: JC_EXP_MORE, target: UPC_LOOP};
            4'd12:   w = '{op: UOP_DONE, cond: JC_ALWAYS,   target: UPC_IDLE};
            default: w = '{op: UOP_NOP,  cond: JC_ALWAYS,   target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- src/mppi_modmul.sv -----
// Pipelined modular multiplier: 30x30 product, Barrett reduction mod P.
// One request per cycle. Depends on mppi_pkg.
`timescale 1ns / 1ps
`include "mod_prime_pow_inverse_unit_defines.svh"

module mppi_modmul
    import mppi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [RES_W-1:0] a,
    input  logic [RES_W-1:0] b,
    output logic             out_valid,
    output logic [RES_W-1:0] y
);

    localparam logic [31:0] P_32  = {2'b00, P_MOD};
    localparam logic [31:0] P2_32 = P_32 + P_32;
    localparam logic [31:0] P3_32 = P2_32 + P_32;

    logic [3:0]        vld_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [61:0]       q2_c;
    logic [30:0]       q3_reg;
    logic [31:0]       lo2_reg;
    logic [31:0]       qp_c;
    logic [31:0]       qp_reg;
    logic [31:0]       lo3_reg;
    logic [31:0]       r_c;
    logic [RES_W-1:0]  y_reg;

    assign q2_c = 62'(prod_reg[PROD_W-1:29]) * 62'(BARRETT_MU);
    assign qp_c = 32'(q3_reg) * P_32;       // only the low word is needed
    assign r_c  = lo3_reg - qp_reg;         // true remainder estimate < 3P

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
        q3_reg   <= q2_c[61:31];
        lo2_reg  <= prod_reg[31:0];
        qp_reg   <= qp_c;
        lo3_reg  <= lo2_reg;
        if (r_c >= P2_32)
        begin
            y_reg <= RES_W'(r_c - P2_32);
        end
        else if (r_c >= P_32)
        begin
            y_reg <= RES_W'(r_c - P_32);
        end
        else
        begin
            y_reg <= RES_W'(r_c);
        end
    end

    assign out_valid = vld_reg[3];
    assign y         = y_reg;

    `MPPI_ASSERT_NEXT(a_mm_stage0, clk, rst_n, in_valid, vld_reg[0])
    `MPPI_ASSERT_IMPL(a_mm_barrett_bound, clk, rst_n, vld_reg[2], r_c < P3_32)
    `MPPI_ASSERT_IMPL(a_mm_reduced, clk, rst_n, out_valid, y < P_MOD)

endmodule

// ----- src/mppi_useq.sv -----
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on mppi_pkg.
`timescale 1ns / 1ps
`include "mod_prime_pow_inverse_unit_defines.svh"

module mppi_useq
    import mppi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output uword_t     uword,
    output logic       idle
);

    upc_t   pc_reg;
    upc_t   pc_next;
    logic   take;
    uword_t w;

    assign w = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (w.cond)
            JC_NEVER:    take = 1'b0;
            JC_ALWAYS:   take = 1'b1;
            JC_NO_START: take = !status.start;
            JC_EXP_ZERO: take = status.exp_zero;
            JC_EXP_MORE: take = status.exp_more;
            default:     take = 1'b1;
        endcase
    end

    assign pc_next = take ? w.target : pc_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UPC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign uword = w;
    assign idle  = (pc_reg == UPC_IDLE);

    `MPPI_ASSERT_ALWAYS(a_sq_pc_range, clk, rst_n, pc_reg <= UPC_DONE)
    `MPPI_ASSERT_NEXT(a_sq_done_to_idle, clk, rst_n, pc_reg == UPC_DONE, pc_reg == UPC_IDLE)
    `MPPI_ASSERT_NEXT(a_sq_wait_idle, clk, rst_n, idle && !status.start, idle)

endmodule

// ----- src/mod_prime_pow_inverse_unit.sv -----
// Top level of the modular power / Fermat inverse unit (modulus 1000000007).
// Depends on mppi_pkg, mppi_useq, mppi_modmul and the assertion header.
`timescale 1ns / 1ps
`include "mod_prime_pow_inverse_unit_defines.svh"

// Usage
//   Request channel: drive func, base and exponent with start high; the request
//   is taken at the rising edge where start is high and busy is low. busy stays
//   high until the result has been produced.
//   func = 0 computes base^exponent mod P, func = 1 computes base^(P-2) mod P,
//   the inverse (0 for a base that is a multiple of P). exponent = 0 gives 1.
//   Result channel: done is high for exactly one cycle with result valid in
//   that cycle. There is no back-pressure; the receiver must take it then.
//   busy is already low in the done cycle, so a new request can be taken then.
// Operation
//   The base is reduced with four compare-subtract steps, then the exponent is
//   scanned LSB first up to its highest set bit on the one shared modular
//   multiplier: for each bit the square and the multiply are issued back to
//   back, the square is written back, then the accumulator is updated if the
//   bit is set. A zero exponent goes to done right after the reduction. busy
//   stays high for the whole computation, so a new request waits until done.
// Reset
//   rst_n is asynchronous; it returns the sequencer to idle and clears done.
//   Only the low EXP_BITS bits of exponent are used.

module mod_prime_pow_inverse_unit
    import mppi_pkg::*;
#(
    parameter int unsigned EXP_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             func,
    input  logic [31:0]      base,
    input  logic [31:0]      exponent,
    output logic             done,
    output logic [RES_W-1:0] result
);

    localparam logic [31:0] P_32 = {2'b00, P_MOD};

    dp_status_t status;
    uword_t     uword;
    logic       seq_idle;
    logic       accept;

    // datapath registers
    logic [31:0]         sq_reg;      // running square; holds the raw base while reducing
    logic [31:0]         sq_next;
    logic [RES_W-1:0]    acc_reg;
    logic [RES_W-1:0]    acc_next;
    logic [EXP_BITS-1:0] exp_reg;
    logic [EXP_BITS-1:0] exp_next;
    logic [RES_W-1:0]    result_reg;
    logic [RES_W-1:0]    result_next;
    logic                done_reg;
    logic                done_next;

    // multiplier hookup
    logic             mul_in_valid;
    logic [RES_W-1:0] mul_a;
    logic             mul_out_valid;
    logic [RES_W-1:0] mul_y;

    mppi_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword),
        .idle   (seq_idle)
    );

    mppi_modmul u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_in_valid),
        .a         (mul_a),
        .b         (sq_reg[RES_W-1:0]),
        .out_valid (mul_out_valid),
        .y         (mul_y)
    );

    assign busy   = !seq_idle;
    assign accept = start && seq_idle;

    assign status.start    = start;
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_more = (exp_reg[EXP_BITS-1:1] != '0);

    // square issues sq*sq, the following step issues acc*sq
    assign mul_in_valid = (uword.op == UOP_ISQ) || (uword.op == UOP_IAM);
    assign mul_a        = (uword.op == UOP_IAM) ? acc_reg : sq_reg[RES_W-1:0];

    always_comb
    begin
        sq_next     = sq_reg;
        acc_next    = acc_reg;
        exp_next    = exp_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (uword.op)
            UOP_IDLE:
            begin
                if (accept)
                begin
                    sq_next  = base;
                    acc_next = RES_W'(1);
                    exp_next = func ? EXP_BITS'(FERMAT_EXP) : EXP_BITS'(exponent);
                end
            end
            UOP_RED:
            begin
                if (sq_reg >= P_32)
                begin
                    sq_next = sq_reg - P_32;
                end
            end
            UOP_WSQ:
            begin
                sq_next = {2'b00, mul_y};
            end
            UOP_WACC:
            begin
                if (exp_reg[0])
                begin
                    acc_next = mul_y;
                end
                exp_next = exp_reg >> 1;
            end
            UOP_DONE:
            begin
                done_next   = 1'b1;
                result_next = acc_reg;
            end
            UOP_NOP, UOP_ISQ, UOP_IAM:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_next;
        acc_reg    <= acc_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `MPPI_ASSERT_IMPL(a_top_done_not_busy, clk, rst_n, done, !busy)
    `MPPI_ASSERT_NEXT(a_top_accept_busy, clk, rst_n, accept, busy)
    `MPPI_ASSERT_IMPL(a_top_mul_writeback, clk, rst_n, uword.op == UOP_WSQ || uword.op == UOP_WACC, mul_out_valid)

endmodule
